FILE: sv/rca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and constants of the rain column animator.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam logic [31:0] SEED_MASK = 32'h4B7E1131;

  localparam logic [4:0] SPEED_SPAN = 5'd3;
  localparam logic [4:0] TRAIL_SPAN = 5'd6;
  localparam logic [3:0] TRAIL_LOW  = 4'd3;

  localparam int RAND_W   = 32;
  localparam int DIGIT_W  = 8;
  localparam int SWEEPS   = RAND_W / DIGIT_W;
  localparam int SWEEP_W  = $clog2(SWEEPS);

  localparam int COL_OUT_W   = 4;
  localparam int HEAD_OUT_W  = 3;
  localparam int SPEED_W     = 2;
  localparam int TRAIL_W     = 4;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EVAL = 6'b000100,
    S_DRAW = 6'b001000,
    S_MOD  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    DRAW_HEAD  = 3'b001,
    DRAW_SPEED = 3'b010,
    DRAW_TRAIL = 3'b100
  } draw_t;

  typedef struct packed {
    logic       start;
    logic [4:0] divisor;
  } mod_req_t;

endpackage

FILE: sv/rca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_in_if / rca_out_if
// Valid/ready channels for command items and per-column results.
// ----------------------------------------------------------------------------
interface rca_in_if;
  import rca_pkg::*;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed_time;

  modport source (output valid, output operation, output seed_time, input ready);
  modport sink (input valid, input operation, input seed_time, output ready);
endinterface

interface rca_out_if;
  import rca_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COL_OUT_W-1:0]  column_index;
  logic [HEAD_OUT_W-1:0] head_row;
  logic [SPEED_W-1:0]    drop_speed;
  logic [TRAIL_W-1:0]    trail_length;
  logic                  last_column;

  modport source (output valid, output column_index, output head_row, output drop_speed,
                  output trail_length, output last_column, input ready);
  modport sink (input valid, input column_index, input head_row, input drop_speed,
                input trail_length, input last_column, output ready);
endinterface

FILE: sv/rain_column_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rain_column_animator
// One falling drop per LED column, state held in a column RAM and advanced
// by a shared LCG and a byte-serial remainder unit.
// operation: columns are handled one after another; a start makes three draws
//   (head, speed, trail) for every column, each an LCG step and a remainder;
//   a tick advances each head and redraws speed and trail of a column that
//   wraps; a result waits while the output is held; one item at a time
// reset: synchronous, all columns read as zero and generator state is zero
// ----------------------------------------------------------------------------
module rain_column_animator #(
  parameter int COLUMNS = 14,
  parameter int ROWS    = 6
) (
  input  logic clk,
  input  logic rst_n,
  rca_in_if.sink    in_ch,
  rca_out_if.source out_ch
);
  import rca_pkg::*;

  localparam int CW     = COLUMNS > 1 ? $clog2(COLUMNS) : 1;
  localparam int HW     = $clog2(ROWS);
  localparam int ENT_W  = HW + SPEED_W + TRAIL_W;
  localparam int CEXT_W = CW > COL_OUT_W ? CW : COL_OUT_W;
  localparam int HEXT_W = HW > HEAD_OUT_W ? HW : HEAD_OUT_W;
  localparam logic [HW:0]   ROWS_W   = (HW + 1)'(ROWS);
  localparam logic [4:0]    ROWS_DIV = 5'(ROWS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

  state_t              state_r;
  draw_t               draw_r;
  logic                op_r;
  logic [RAND_W-1:0]   lcg_r, lcg_nxt;
  logic [CW-1:0]       col_r;
  logic [HW-1:0]       head_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [TRAIL_W-1:0]  trail_r;
  logic [COLUMNS-1:0]  written_r;

  logic [ENT_W-1:0]    rdata, ent, wdata;
  logic                mem_we, emit_fire;
  logic [HW:0]         sum;
  logic [HW-1:0]       head_adv;

  mod_req_t            mreq;
  logic                mdone;
  logic [3:0]          mrem;

  logic                  out_valid_r;
  logic [COL_OUT_W-1:0]  out_col_r;
  logic [HEAD_OUT_W-1:0] out_head_r;
  logic [SPEED_W-1:0]    out_speed_r;
  logic [TRAIL_W-1:0]    out_trail_r;
  logic                  out_last_r;
  logic [CEXT_W-1:0]     col_ext;
  logic [HEXT_W-1:0]     head_ext;

  assign lcg_nxt   = lcg_r * LCG_MUL + LCG_ADD;
  assign ent       = written_r[col_r] ? rdata : '0;
  assign sum       = {1'b0, ent[ENT_W-1 -: HW]} + (HW + 1)'(ent[TRAIL_W +: SPEED_W]);
  assign head_adv  = (sum >= ROWS_W) ? HW'(sum - ROWS_W) : sum[HW-1:0];
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign mem_we    = emit_fire;
  assign wdata     = {head_r, speed_r, trail_r};
  assign col_ext   = CEXT_W'(col_r);
  assign head_ext  = HEXT_W'(head_r);

  always_comb begin
    mreq.start = (state_r == S_DRAW);
    unique case (draw_r)
      DRAW_HEAD:  mreq.divisor = ROWS_DIV;
      DRAW_SPEED: mreq.divisor = SPEED_SPAN;
      DRAW_TRAIL: mreq.divisor = TRAIL_SPAN;
      default:    mreq.divisor = ROWS_DIV;
    endcase
  end

  rca_ram #(
    .WIDTH (ENT_W),
    .DEPTH (COLUMNS)
  ) u_col_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_r),
    .wdata (wdata),
    .raddr (col_r),
    .rdata (rdata)
  );

  rca_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .value (lcg_nxt),
    .done  (mdone),
    .rem   (mrem)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      draw_r      <= DRAW_HEAD;
      lcg_r       <= '0;
      col_r       <= '0;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            col_r   <= '0;
            state_r <= S_READ;
            if (in_ch.operation == OP_START) begin
              lcg_r <= in_ch.seed_time ^ SEED_MASK;
            end
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          if (op_r == OP_START) begin
            draw_r  <= DRAW_HEAD;
            state_r <= S_DRAW;
          end else if (head_adv < ent[ENT_W-1 -: HW]) begin
            draw_r  <= DRAW_SPEED;
            state_r <= S_DRAW;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_DRAW: begin
          lcg_r   <= lcg_nxt;
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (mdone) begin
            unique case (draw_r)
              DRAW_HEAD: begin
                draw_r  <= DRAW_SPEED;
                state_r <= S_DRAW;
              end
              DRAW_SPEED: begin
                draw_r  <= DRAW_TRAIL;
                state_r <= S_DRAW;
              end
              default: state_r <= S_EMIT;
            endcase
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            written_r[col_r] <= 1'b1;
            if (col_r == LAST_COL) begin
              state_r <= S_IDLE;
            end else begin
              col_r   <= col_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      op_r <= in_ch.operation;
    end
    if (state_r == S_EVAL) begin
      head_r  <= (op_r == OP_TICK) ? head_adv : ent[ENT_W-1 -: HW];
      speed_r <= ent[TRAIL_W +: SPEED_W];
      trail_r <= ent[TRAIL_W-1:0];
    end
    if (state_r == S_MOD && mdone) begin
      unique case (draw_r)
        DRAW_HEAD:  head_r  <= mrem[HW-1:0];
        DRAW_SPEED: speed_r <= mrem[SPEED_W-1:0] + 1'b1;
        DRAW_TRAIL: trail_r <= mrem + TRAIL_LOW;
        default:    trail_r <= mrem + TRAIL_LOW;
      endcase
    end
    if (emit_fire) begin
      out_col_r   <= col_ext[COL_OUT_W-1:0];
      out_head_r  <= head_ext[HEAD_OUT_W-1:0];
      out_speed_r <= speed_r;
      out_trail_r <= trail_r;
      out_last_r  <= (col_r == LAST_COL);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_index = out_col_r;
  assign out_ch.head_row     = out_head_r;
  assign out_ch.drop_speed   = out_speed_r;
  assign out_ch.trail_length = out_trail_r;
  assign out_ch.last_column  = out_last_r;

endmodule

FILE: sv/rca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rca_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_mod
// Remainder of a 32-bit random value by a small divisor, one byte per cycle.
// ----------------------------------------------------------------------------
module rca_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  rca_pkg::mod_req_t req,
  input  logic [31:0]       value,
  output logic              done,
  output logic [3:0]        rem
);
  import rca_pkg::*;

  logic [RAND_W-1:0]  val_r, val_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic [4:0]         div_r;
  logic [SWEEP_W-1:0] cnt_r;
  logic               busy_r, done_r;

  always_comb begin
    logic [4:0] t;
    t       = 5'd0;
    rem_nxt = rem_r;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {rem_nxt, val_r[RAND_W-1-i]};
      if (t >= div_r) begin
        t = t - div_r;
      end
      rem_nxt = t[3:0];
    end
    val_nxt = val_r << DIGIT_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        done_r <= (cnt_r == SWEEP_W'(SWEEPS - 1));
        if (cnt_r == SWEEP_W'(SWEEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val_r <= value;
      rem_r <= 4'd0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      val_r <= val_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: verif/tb_rain_column_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rain_column_animator
// Drives start and tick commands into the rain column animator and checks
// every per-column report against a cycle-free model of the drops and the
// LCG. Directed commands cover ticks before any start, extreme seeds, a seed
// that zeroes the generator and back-to-back starts; random commands follow,
// mostly ticks so the drops wrap and redraw many times. Both channels stall
// at random, with one calm stretch and drain pauses on the command side.
// ----------------------------------------------------------------------------
module tb_rain_column_animator;
  import rca_pkg::*;

  localparam int NUM_COLS     = 14;
  localparam int NUM_ROWS     = 6;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_PCT     = 21;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        op;
    logic [31:0] seed;
    logic        drain_first;
  } rain_cmd_t;

  typedef struct packed {
    logic [3:0] column;
    logic [2:0] head;
    logic [1:0] speed;
    logic [3:0] trail;
    logic       last;
  } column_report_t;

  logic clk;
  logic rst_n;
  logic calm;

  rca_in_if  in_bus ();
  rca_out_if out_bus ();

  rain_column_animator #(
    .COLUMNS(NUM_COLS),
    .ROWS   (NUM_ROWS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  rain_cmd_t      cmd_queue[$];
  column_report_t report_queue[$];

  logic [2:0]  drop_head  [NUM_COLS];
  logic [1:0]  drop_speed [NUM_COLS];
  logic [3:0]  drop_trail [NUM_COLS];
  logic [31:0] lcg_state;

  int err_cnt;
  int sent_cnt;
  bit cmd_taken;

  // calm stretch with no idling on either side
  assign calm = (sent_cnt >= 150) && (sent_cnt < 260);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [31:0] lcg_draw();
    lcg_state = lcg_state * LCG_MUL + LCG_ADD;
    return lcg_state;
  endfunction

  function automatic void add_cmd(logic op, logic [31:0] seed, logic drain_first);
    rain_cmd_t cmd;
    cmd.op          = op;
    cmd.seed        = seed;
    cmd.drain_first = drain_first;
    cmd_queue.push_back(cmd);
  endfunction

  // advance the drop model by one command and queue the column reports
  function automatic void predict_frame(logic op, logic [31:0] seed);
    int             prev_row;
    int             next_row;
    column_report_t rep;
    if (op == OP_START) begin
      lcg_state = seed ^ SEED_MASK;
      for (int c = 0; c < NUM_COLS; c++) begin
        drop_head[c]  = 3'(lcg_draw() % NUM_ROWS);
        drop_speed[c] = 2'(lcg_draw() % SPEED_SPAN + 1);
        drop_trail[c] = 4'(lcg_draw() % TRAIL_SPAN + TRAIL_LOW);
      end
    end else begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prev_row = int'(drop_head[c]);
        next_row = (prev_row + int'(drop_speed[c])) % NUM_ROWS;
        drop_head[c] = 3'(next_row);
        // wrapped past the bottom row
        if (next_row < prev_row) begin
          drop_speed[c] = 2'(lcg_draw() % SPEED_SPAN + 1);
          drop_trail[c] = 4'(lcg_draw() % TRAIL_SPAN + TRAIL_LOW);
        end
      end
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      rep.column = 4'(c);
      rep.head   = drop_head[c];
      rep.speed  = drop_speed[c];
      rep.trail  = drop_trail[c];
      rep.last   = (c == NUM_COLS - 1);
      report_queue.push_back(rep);
    end
  endfunction

  function automatic void check_field(string label, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endfunction

  // monitor: command transfers feed the model, result transfers are checked
  always @(posedge clk) begin
    column_report_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_frame(in_bus.operation, in_bus.seed_time);
        cmd_taken = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (report_queue.size() == 0) begin
          err_cnt++;
          $display("%0t ns: unexpected result, expected none, got column %0d head %0d",
                   $time, out_bus.column_index, out_bus.head_row);
        end else begin
          want = report_queue.pop_front();
          check_field("column_index", want.column, out_bus.column_index);
          check_field("head_row", 4'(want.head), 4'(out_bus.head_row));
          check_field("drop_speed", 4'(want.speed), 4'(out_bus.drop_speed));
          check_field("trail_length", want.trail, out_bus.trail_length);
          check_field("last_column", 4'(want.last), 4'(out_bus.last_column));
        end
      end
    end
  end

  // driver: next command goes out at the falling edge after a transfer
  always @(negedge clk) begin
    rain_cmd_t cur;
    if (rst_n) begin
      if (cmd_taken || !in_bus.valid) begin
        cmd_taken = 1'b0;
        if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
            !(cmd_queue[0].drain_first && report_queue.size() > 0)) begin
          cur = cmd_queue.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.operation <= cur.op;
          in_bus.seed_time <= cur.seed;
          sent_cnt++;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_START;
    in_bus.seed_time = '0;
    out_bus.ready    = 1'b0;
    err_cnt          = 0;
    sent_cnt         = 0;
    cmd_taken        = 1'b0;
    lcg_state        = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      drop_head[c]  = '0;
      drop_speed[c] = '0;
      drop_trail[c] = '0;
    end

    // ticks before any start leave every column at zero
    add_cmd(OP_TICK, 32'h0000_0000, 1'b0);
    add_cmd(OP_TICK, 32'hFFFF_FFFF, 1'b0);
    add_cmd(OP_START, 32'h0000_0000, 1'b0);
    repeat (3) add_cmd(OP_TICK, 32'h0000_0000, 1'b0);
    add_cmd(OP_START, 32'hFFFF_FFFF, 1'b0);
    repeat (3) add_cmd(OP_TICK, 32'hFFFF_FFFF, 1'b0);
    // seed that zeroes the generator, sent once the block has drained
    add_cmd(OP_START, SEED_MASK, 1'b1);
    repeat (4) add_cmd(OP_TICK, 32'h5555_5555, 1'b0);
    // back-to-back starts
    add_cmd(OP_START, 32'h8000_0000, 1'b0);
    add_cmd(OP_START, 32'h0000_0001, 1'b0);
    repeat (3) add_cmd(OP_TICK, 32'hAAAA_AAAA, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_cmd(($urandom_range(99) < 12) ? OP_START : OP_TICK, $urandom, i == 300);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_queue.size() > 0 || in_bus.valid) @(posedge clk);
    while (report_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("PASS rain_column_animator");
    end else begin
      $display("FAIL rain_column_animator");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t ns: timeout", $time);
    $display("FAIL rain_column_animator");
    $finish;
  end

endmodule
